// ----- design/bptc_pkg.sv -----
// ----------------------------------------------------------------------------
// bptc_pkg
// Shared types and constants for the barometric compensation pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bptc_pkg;

  // pipeline depth of the top level
  localparam int NumStages = 12;

  // configuration port
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 24;

  typedef enum logic [CfgIdxW-1:0] {
    RegTempCoefs = 3'd0,
    RegC00       = 3'd1,
    RegC10       = 3'd2,
    RegC01       = 3'd3,
    RegC11       = 3'd4,
    RegC20       = 3'd5,
    RegC21       = 3'd6,
    RegC30       = 3'd7
  } cfg_reg_e;

  // round(2^40 / 253952)
  localparam logic signed [46:0] PscRecip = 47'sd4329604;

  // split multiply, round(x * y / 2^26) + z
  localparam int MulqXW    = 44;
  localparam int MulqYW    = 37;
  localparam int MulqRW    = 56;
  localparam int MulqSplit = 22;
  localparam int MulqFrac  = 26;
  localparam int MulqPhW   = MulqXW - MulqSplit + MulqYW;
  localparam int MulqPlW   = MulqSplit + 1 + MulqYW;
  localparam int MulqFullW = MulqXW + MulqYW;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } mulq_en_t;

endpackage

`default_nettype wire

// ----- design/bptc_mulq.sv -----
// ----------------------------------------------------------------------------
// bptc_mulq
// Three-stage signed multiply with rounding: r = round(x * y / 2^26) + z.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bptc_mulq (
  input  wire logic                                  clk_i,
  input  wire bptc_pkg::mulq_en_t                    en_i,
  input  wire logic signed [bptc_pkg::MulqXW-1:0]    x_i,
  input  wire logic signed [bptc_pkg::MulqYW-1:0]    y_i,
  input  wire logic signed [bptc_pkg::MulqRW-1:0]    z_i,
  output logic signed      [bptc_pkg::MulqRW-1:0]    r_o
);
  import bptc_pkg::*;

  logic signed [MulqXW-MulqSplit-1:0] xh;
  logic signed [MulqSplit:0]          xl;
  logic signed [MulqPhW-1:0]          ph_d, ph_q;
  logic signed [MulqPlW-1:0]          pl_d, pl_q;
  logic signed [MulqRW-1:0]           z1_q, z2_q;
  logic signed [MulqFullW-1:0]        full_d, full_q;
  logic signed [MulqFullW-1:0]        rnd_half;
  logic signed [MulqRW-1:0]           r_d, r_q;

  assign rnd_half = MulqFullW'(1) <<< (MulqFrac - 1);

  // partial products on the upper and lower halves of x
  assign xh   = x_i[MulqXW-1:MulqSplit];
  assign xl   = {1'b0, x_i[MulqSplit-1:0]};
  assign ph_d = MulqPhW'(xh) * MulqPhW'(y_i);
  assign pl_d = MulqPlW'(xl) * MulqPlW'(y_i);

  assign full_d = (MulqFullW'(ph_q) <<< MulqSplit) + MulqFullW'(pl_q);
  assign r_d    = MulqRW'((full_q + rnd_half) >>> MulqFrac) + z2_q;

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      ph_q <= ph_d;
      pl_q <= pl_d;
      z1_q <= z_i;
    end
    if (en_i.s2) begin
      full_q <= full_d;
      z2_q   <= z1_q;
    end
    if (en_i.s3) begin
      r_q <= r_d;
    end
  end

  assign r_o = r_q;

endmodule

`default_nettype wire

// ----- design/baro_pressure_temp_compensation_unit.sv -----
// ----------------------------------------------------------------------------
// baro_pressure_temp_compensation_unit
// Throughput: one request per cycle unless every stage is full and the output
// is stalled; each stage holds while its successor is full and stalled, and
// free stages keep filling while the output waits.
// Reset clears all eight calibration registers to zero and empties the pipe.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module baro_pressure_temp_compensation_unit (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [bptc_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  wire logic [bptc_pkg::CfgDataW-1:0]      cfg_wdata_i,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic signed [23:0]                 raw_pressure_i,
  input  wire logic signed [23:0]                 raw_temperature_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic signed [23:0]                      temperature_out_o,
  output logic signed [31:0]                      pressure_out_o
);
  import bptc_pkg::*;

  // calibration registers
  logic [23:0]        temp_coefs_q;
  logic signed [19:0] c00_q, c10_q;
  logic signed [15:0] c01_q, c11_q, c20_q, c21_q, c30_q;
  logic signed [11:0] c0, c1;

  // pipeline control
  logic [NumStages-1:0] v_q, en;
  logic                 in_acc, out_acc;
  mulq_en_t             tp_en, a_en, b_en, c_en;

  // stage data
  logic signed [46:0] s1_pp_q;
  logic signed [35:0] s1_tc1_q;
  logic signed [39:0] s1_tc01_q;
  logic signed [23:0] s1_rt_q;

  logic signed [46:0] psc_r;
  logic signed [31:0] psc_d;
  logic signed [35:0] temp_r;
  logic signed [23:0] temp_d;
  logic signed [39:0] tt_r;
  logic signed [31:0] s2_psc_q;
  logic signed [23:0] s2_temp_q;
  logic signed [36:0] s2_tt_q;
  logic signed [30:0] s2_tsc_q;

  logic signed [47:0] s3_pc30_q, s3_pc21_q;
  logic signed [31:0] s3_psc_q;
  logic signed [23:0] s3_temp_q;
  logic signed [36:0] s3_tt_q;

  logic signed [47:0] a_d, b_d;
  logic signed [37:0] s4_a_q, s4_b_q;
  logic signed [31:0] s4_psc_q;
  logic signed [23:0] s4_temp_q;
  logic signed [36:0] s4_tt_q;

  logic signed [37:0] s5_b_q;
  logic signed [31:0] s5_psc_q, s6_psc_q, s7_psc_q;
  logic signed [23:0] s5_temp_q, s6_temp_q, s7_temp_q, s8_temp_q, s9_temp_q;
  logic signed [23:0] s10_temp_q, s11_temp_q, s12_temp_q;
  logic signed [36:0] s5_tt_q, s6_tt_q, s7_tt_q;

  logic signed [47:0] s9_q3_q, s10_q3_q;
  logic signed [49:0] s11_sum_q;
  logic signed [49:0] pres_r;
  logic signed [31:0] pres_d, s12_pres_q;

  logic signed [MulqRW-1:0] tp_r, a_r, b_r, c_r;
  logic signed [MulqRW-1:0] a_z, c_z, zero_z;

  // --------------------------------------------------------------------------
  // configuration
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_coefs_q <= '0;
      c00_q        <= '0;
      c10_q        <= '0;
      c01_q        <= '0;
      c11_q        <= '0;
      c20_q        <= '0;
      c21_q        <= '0;
      c30_q        <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        RegTempCoefs: temp_coefs_q <= cfg_wdata_i;
        RegC00:       c00_q        <= cfg_wdata_i[19:0];
        RegC10:       c10_q        <= cfg_wdata_i[19:0];
        RegC01:       c01_q        <= cfg_wdata_i[15:0];
        RegC11:       c11_q        <= cfg_wdata_i[15:0];
        RegC20:       c20_q        <= cfg_wdata_i[15:0];
        RegC21:       c21_q        <= cfg_wdata_i[15:0];
        RegC30:       c30_q        <= cfg_wdata_i[15:0];
        default:      ;
      endcase
    end
  end

  assign c0 = temp_coefs_q[23:12];
  assign c1 = temp_coefs_q[11:0];

  // --------------------------------------------------------------------------
  // pipeline control
  // --------------------------------------------------------------------------
  for (genvar k = 0; k < NumStages; k++) begin : g_en
    assign en[k] = ~(&v_q[NumStages-1:k]) | ~out_stall_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign in_stall_o  = ~en[0];
  assign out_valid_o = v_q[NumStages-1];
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign out_acc     = out_valid_o & ~out_stall_i;

  assign tp_en = '{s1: en[2], s2: en[3], s3: en[4]};
  assign a_en  = '{s1: en[4], s2: en[5], s3: en[6]};
  assign b_en  = '{s1: en[5], s2: en[6], s3: en[7]};
  assign c_en  = '{s1: en[7], s2: en[8], s3: en[9]};

  // --------------------------------------------------------------------------
  // datapath
  // --------------------------------------------------------------------------
  // normalize and temperature terms
  assign psc_r = (s1_pp_q + 47'sd8192) >>> 14;
  assign psc_d = ((&psc_r[46:31]) | ~(|psc_r[46:31])) ? psc_r[31:0] :
                 (psc_r[46] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);

  assign temp_r = ((s1_tc1_q + 36'sd1024) >>> 11) + (36'(c0) <<< 7);
  assign temp_d = ((&temp_r[35:23]) | ~(|temp_r[35:23])) ? temp_r[23:0] :
                  (temp_r[35] ? 24'sh80_0000 : 24'sh7F_FFFF);

  assign tt_r = (s1_tc01_q + 40'sd4) >>> 3;

  // pressure polynomial inner terms
  assign a_d = (48'(c20_q) <<< 16) + ((s3_pc30_q + 48'sd512) >>> 10);
  assign b_d = (48'(c11_q) <<< 16) + ((s3_pc21_q + 48'sd512) >>> 10);

  assign zero_z = '0;
  assign a_z    = MulqRW'(c10_q) <<< 16;
  assign c_z    = (MulqRW'(c00_q) <<< 16) + MulqRW'(s7_tt_q);

  assign pres_r = (s11_sum_q + 50'sd512) >>> 10;
  assign pres_d = ((&pres_r[49:31]) | ~(|pres_r[49:31])) ? pres_r[31:0] :
                  (pres_r[49] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s1_pp_q   <= 47'(raw_pressure_i) * PscRecip;
      s1_tc1_q  <= 36'(raw_temperature_i) * 36'(c1);
      s1_tc01_q <= 40'(raw_temperature_i) * 40'(c01_q);
      s1_rt_q   <= raw_temperature_i;
    end
    if (en[1]) begin
      s2_psc_q  <= psc_d;
      s2_temp_q <= temp_d;
      s2_tt_q   <= tt_r[36:0];
      s2_tsc_q  <= {s1_rt_q, 7'b0};
    end
    if (en[2]) begin
      s3_pc30_q <= 48'(s2_psc_q) * 48'(c30_q);
      s3_pc21_q <= 48'(s2_psc_q) * 48'(c21_q);
      s3_psc_q  <= s2_psc_q;
      s3_temp_q <= s2_temp_q;
      s3_tt_q   <= s2_tt_q;
    end
    if (en[3]) begin
      s4_a_q    <= a_d[37:0];
      s4_b_q    <= b_d[37:0];
      s4_psc_q  <= s3_psc_q;
      s4_temp_q <= s3_temp_q;
      s4_tt_q   <= s3_tt_q;
    end
    if (en[4]) begin
      s5_b_q    <= s4_b_q;
      s5_psc_q  <= s4_psc_q;
      s5_temp_q <= s4_temp_q;
      s5_tt_q   <= s4_tt_q;
    end
    if (en[5]) begin
      s6_psc_q  <= s5_psc_q;
      s6_temp_q <= s5_temp_q;
      s6_tt_q   <= s5_tt_q;
    end
    if (en[6]) begin
      s7_psc_q  <= s6_psc_q;
      s7_temp_q <= s6_temp_q;
      s7_tt_q   <= s6_tt_q;
    end
    if (en[7]) begin
      s8_temp_q <= s7_temp_q;
    end
    if (en[8]) begin
      s9_q3_q   <= b_r[47:0];
      s9_temp_q <= s8_temp_q;
    end
    if (en[9]) begin
      s10_q3_q   <= s9_q3_q;
      s10_temp_q <= s9_temp_q;
    end
    if (en[10]) begin
      s11_sum_q  <= c_r[49:0] + 50'(s10_q3_q);
      s11_temp_q <= s10_temp_q;
    end
    if (en[11]) begin
      s12_pres_q <= pres_d;
      s12_temp_q <= s11_temp_q;
    end
  end

  // tp = round(tsc * psc / 2^26)
  bptc_mulq u_mulq_tp (
    .clk_i (clk_i),
    .en_i  (tp_en),
    .x_i   (MulqXW'(s2_tsc_q)),
    .y_i   (MulqYW'(s2_psc_q)),
    .z_i   (zero_z),
    .r_o   (tp_r)
  );

  // q2 = c10 * 2^16 + round(a * psc / 2^26)
  bptc_mulq u_mulq_a (
    .clk_i (clk_i),
    .en_i  (a_en),
    .x_i   (MulqXW'(s4_a_q)),
    .y_i   (MulqYW'(s4_psc_q)),
    .z_i   (a_z),
    .r_o   (a_r)
  );

  // q3 = round(b * tp / 2^26)
  bptc_mulq u_mulq_b (
    .clk_i (clk_i),
    .en_i  (b_en),
    .x_i   (MulqXW'(s5_b_q)),
    .y_i   (tp_r[MulqYW-1:0]),
    .z_i   (zero_z),
    .r_o   (b_r)
  );

  // c00 * 2^16 + tsc term + round(q2 * psc / 2^26)
  bptc_mulq u_mulq_c (
    .clk_i (clk_i),
    .en_i  (c_en),
    .x_i   (a_r[MulqXW-1:0]),
    .y_i   (MulqYW'(s7_psc_q)),
    .z_i   (c_z),
    .r_o   (c_r)
  );

  assign temperature_out_o = s12_temp_q;
  assign pressure_out_o    = s12_pres_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_item_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |->
      $countones(v_q) == $past($countones(v_q)) + int'($past(in_acc))
                         - int'($past(out_acc)))
    else $error("pipeline item count mismatch");

  a_stall_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&v_q) && out_stall_i)
    else $error("input stalled while pipeline has room");

  a_accept_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> v_q[0])
    else $error("accepted request lost at first stage");

  a_hold_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(s12_pres_q) && $stable(s12_temp_q))
    else $error("stalled result changed");

endmodule

`default_nettype wire

// ----- tb/tb_baro_pressure_temp_compensation_unit.sv -----
// ----------------------------------------------------------------------------
// tb_baro_pressure_temp_compensation_unit
// Self-checking bench for the barometric compensation pipeline. A scripted
// table covers reset values, coefficient limits, narrow-register truncation
// and the pressure normalisation clamp. Random sample pairs follow under
// random calibration sets, sent in bursts against a receiver that stalls.
// Every result is compared with a typed expectation or a bit-exact fixed-point predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_baro_pressure_temp_compensation_unit;
  import bptc_pkg::*;

  localparam int ClkPeriod     = 4;
  localparam int ResetCycles   = 12;
  localparam int RandPhases    = 7;
  localparam int ItemsPerPhase = 150;
  localparam int QuietLimit    = 2000;
  localparam int MaxReports    = 10;

  typedef logic signed [127:0] wide_t;

  localparam wide_t PscScale = 4329604;
  localparam wide_t Lim32Lo  = -(wide_t'(1) <<< 31);
  localparam wide_t Lim32Hi  = (wide_t'(1) <<< 31) - 1;
  localparam wide_t Lim24Lo  = -(wide_t'(1) <<< 23);
  localparam wide_t Lim24Hi  = (wide_t'(1) <<< 23) - 1;

  localparam logic signed [23:0] RawMax  = 24'sh7FFFFF;
  localparam logic signed [23:0] RawMin  = 24'sh800000;
  // raw pressure at which the normalised value reaches 32.0
  localparam logic signed [23:0] PscEdge = 24'sd8126464;

  typedef struct packed {
    logic signed [23:0] temperature;
    logic signed [31:0] pressure;
  } reading_t;

  typedef enum logic [0:0] {StepWrite, StepSample} step_kind_e;

  typedef struct packed {
    step_kind_e         kind;
    cfg_reg_e           sel;
    logic [23:0]        wdata;
    logic signed [23:0] rp;
    logic signed [23:0] rt;
    logic               known;
    reading_t           typed;
  } step_t;

  typedef enum logic [1:0] {RxOpen, RxRandom, RxBurst, RxHeavy} rx_mode_e;

  logic                clk_i = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;
  logic                in_valid = 1'b0;
  logic signed [23:0]  raw_pressure = '0;
  logic signed [23:0]  raw_temperature = '0;
  logic                out_stall = 1'b0;
  logic                in_stall;
  logic                out_valid;
  logic signed [23:0]  temperature_out;
  logic signed [31:0]  pressure_out;

  // typed expectation for the request currently on the input
  logic                item_known = 1'b0;
  reading_t            item_typed = '0;

  logic [23:0]         cal_regs [8];
  reading_t            pending_readings [$];
  reading_t            want;
  step_t               script [$];

  int fail_count   = 0;
  int n_requests   = 0;
  int n_results    = 0;
  int n_writes     = 0;
  int n_sat_temp   = 0;
  int n_sat_pres   = 0;
  int quiet_cycles = 0;

  rx_mode_e    rx_mode = RxOpen;
  int          rx_left = 0;
  int unsigned rx_tick = 0;

  baro_pressure_temp_compensation_unit uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_index_i       (cfg_index),
    .cfg_wdata_i       (cfg_wdata),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .raw_pressure_i    (raw_pressure),
    .raw_temperature_i (raw_temperature),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .temperature_out_o (temperature_out),
    .pressure_out_o    (pressure_out)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // floor((v + 2^(s-1)) / 2^s)
  function automatic wide_t round_shift(wide_t v, int unsigned s);
    wide_t half;
    half = wide_t'(1) <<< (s - 1);
    return (v + half) >>> s;
  endfunction

  function automatic wide_t clamp(wide_t v, wide_t lo, wide_t hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic reading_t compensate(logic signed [23:0] rp, logic signed [23:0] rt);
    wide_t c0, c1, c00, c10, c01, c11, c20, c21, c30;
    wide_t tsc, psc, temp, a, q2, b, tp, q3, sum, pres;
    reading_t r;
    c0  = wide_t'($signed(cal_regs[RegTempCoefs][23:12]));
    c1  = wide_t'($signed(cal_regs[RegTempCoefs][11:0]));
    c00 = wide_t'($signed(cal_regs[RegC00][19:0]));
    c10 = wide_t'($signed(cal_regs[RegC10][19:0]));
    c01 = wide_t'($signed(cal_regs[RegC01][15:0]));
    c11 = wide_t'($signed(cal_regs[RegC11][15:0]));
    c20 = wide_t'($signed(cal_regs[RegC20][15:0]));
    c21 = wide_t'($signed(cal_regs[RegC21][15:0]));
    c30 = wide_t'($signed(cal_regs[RegC30][15:0]));
    tsc = wide_t'(rt);
    tsc = tsc <<< 7;
    psc = wide_t'(rp);
    psc = clamp(round_shift(psc * PscScale, 14), Lim32Lo, Lim32Hi);
    temp = clamp(c0 * 128 + round_shift(tsc * c1, 18), Lim24Lo, Lim24Hi);
    // polynomial terms in q.16
    a    = c20 * 65536 + round_shift(psc * c30, 10);
    q2   = c10 * 65536 + round_shift(a * psc, 26);
    b    = c11 * 65536 + round_shift(psc * c21, 10);
    tp   = round_shift(tsc * psc, 26);
    q3   = round_shift(b * tp, 26);
    sum  = c00 * 65536 + round_shift(q2 * psc, 26) + round_shift(tsc * c01, 10) + q3;
    pres = clamp(round_shift(sum, 10), Lim32Lo, Lim32Hi);
    r.temperature = temp[23:0];
    r.pressure    = pres[31:0];
    return r;
  endfunction

  function automatic void log_failure(string msg);
    if (fail_count < MaxReports) $display("%0t: %s", $time, msg);
    fail_count++;
  endfunction

  function automatic step_t mk_write(cfg_reg_e sel, logic [23:0] data);
    step_t s;
    s = '0;
    s.kind  = StepWrite;
    s.sel   = sel;
    s.wdata = data;
    return s;
  endfunction

  function automatic step_t mk_sample(logic signed [23:0] rp, logic signed [23:0] rt);
    step_t s;
    s = '0;
    s.kind = StepSample;
    s.rp   = rp;
    s.rt   = rt;
    return s;
  endfunction

  function automatic step_t mk_known(logic signed [23:0] rp, logic signed [23:0] rt,
                                     logic signed [23:0] t, logic signed [31:0] p);
    step_t s;
    s = mk_sample(rp, rt);
    s.known             = 1'b1;
    s.typed.temperature = t;
    s.typed.pressure    = p;
    return s;
  endfunction

  function automatic logic signed [23:0] extreme_value();
    case ($urandom_range(0, 4))
      0: return RawMax;
      1: return RawMin;
      2: return 24'sd0;
      3: return 24'sd1;
      default: return -24'sd1;
    endcase
  endfunction

  function automatic logic [23:0] pick_coef(cfg_reg_e sel);
    logic top;
    top = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 5))
      0: begin
        case (sel)
          RegTempCoefs:   return top ? 24'h7FF7FF : 24'h800800;
          RegC00, RegC10: return top ? 24'h07FFFF : 24'h080000;
          default:        return top ? 24'h007FFF : 24'h008000;
        endcase
      end
      1: return 24'h000000;
      2: return 24'($urandom_range(0, 4095)) - 24'd2048;
      default: return 24'($urandom);
    endcase
  endfunction

  // called at a falling edge
  task automatic write_reg(input cfg_reg_e sel, input logic [23:0] data);
    cfg_we    = 1'b1;
    cfg_index = sel;
    cfg_wdata = data;
    case (sel)
      RegTempCoefs:   cal_regs[sel] = data;
      RegC00, RegC10: cal_regs[sel] = data & 24'h0FFFFF;
      default:        cal_regs[sel] = data & 24'h00FFFF;
    endcase
    n_writes++;
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  task automatic wait_idle();
    in_valid = 1'b0;
    while (pending_readings.size() != 0) @(negedge clk_i);
    repeat (NumStages + 2) @(negedge clk_i);
  endtask

  // holds the request until it is taken, returns at the next falling edge
  task automatic send_item(input logic signed [23:0] rp, input logic signed [23:0] rt,
                           input logic known, input reading_t typed);
    in_valid        = 1'b1;
    raw_pressure    = rp;
    raw_temperature = rt;
    item_known      = known;
    item_typed      = typed;
    do @(posedge clk_i); while (in_stall);
    @(negedge clk_i);
  endtask

  // receiver stall pattern
  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(16, 200);
    end
    rx_left--;
    rx_tick++;
    case (rx_mode)
      RxOpen:   out_stall = 1'b0;
      RxRandom: out_stall = ($urandom_range(0, 3) == 0);
      RxBurst:  out_stall = ((rx_tick % 16) < 10);
      default:  out_stall = ($urandom_range(0, 1) == 0);
    endcase
  end

  // accepted requests
  always @(posedge clk_i) begin
    if (rst_n && in_valid && !in_stall) begin
      n_requests++;
      if (item_known) pending_readings.push_back(item_typed);
      else pending_readings.push_back(compensate(raw_pressure, raw_temperature));
    end
  end

  // accepted results
  always @(posedge clk_i) begin
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (pending_readings.size() == 0) begin
        log_failure($sformatf("unexpected result: temperature %0d pressure %0d",
                              temperature_out, pressure_out));
      end else begin
        want = pending_readings.pop_front();
        if (temperature_out !== want.temperature)
          log_failure($sformatf("temperature: expected %0d, got %0d",
                                want.temperature, temperature_out));
        if (pressure_out !== want.pressure)
          log_failure($sformatf("pressure: expected %0d, got %0d",
                                want.pressure, pressure_out));
        if (want.temperature == 24'sh7FFFFF || want.temperature == 24'sh800000)
          n_sat_temp++;
        if (want.pressure == 32'sh7FFFFFFF || want.pressure == 32'sh80000000)
          n_sat_pres++;
      end
    end
  end

  // no progress watchdog
  always @(posedge clk_i) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("no progress for %0d cycles", QuietLimit);
      $display("tb_baro_pressure_temp_compensation_unit: errors");
      $finish;
    end
  end

  initial begin
    int burst_left;
    int gap;
    logic signed [23:0] rp;
    logic signed [23:0] rt;

    foreach (cal_regs[i]) cal_regs[i] = '0;

    script = '{
      // all coefficients zero after reset
      mk_known(RawMax, RawMin, 24'sd0, 32'sd0),
      mk_known(RawMin, RawMax, 24'sd0, 32'sd0),
      mk_known(24'sd0, 24'sd0, 24'sd0, 32'sd0),
      // only c0 set: temperature is 128 * c0, pressure stays zero
      mk_write(RegTempCoefs, 24'h7FF000),
      mk_known(24'sd0, RawMax, 24'sd262016, 32'sd0),
      mk_known(RawMin, RawMin, 24'sd262016, 32'sd0),
      // every coefficient at its positive limit
      mk_write(RegTempCoefs, 24'h7FF7FF),
      mk_write(RegC00, 24'h07FFFF),
      mk_write(RegC10, 24'h07FFFF),
      mk_write(RegC01, 24'h007FFF),
      mk_write(RegC11, 24'h007FFF),
      mk_write(RegC20, 24'h007FFF),
      mk_write(RegC21, 24'h007FFF),
      mk_write(RegC30, 24'h007FFF),
      mk_sample(RawMax, RawMax),
      mk_sample(PscEdge - 24'sd1, 24'sd0),
      mk_sample(PscEdge, 24'sd1),
      mk_sample(PscEdge + 24'sd1, -24'sd1),
      mk_sample(-PscEdge, 24'sd100),
      mk_sample(-PscEdge - 24'sd1, -24'sd100),
      mk_sample(RawMin, RawMin),
      mk_sample(24'sd253952, 24'sd524288),
      // negative limits, upper data bits beyond the register dropped
      mk_write(RegTempCoefs, 24'h800800),
      mk_write(RegC00, 24'hF80000),
      mk_write(RegC10, 24'hA80000),
      mk_write(RegC01, 24'hFF8000),
      mk_write(RegC11, 24'h128000),
      mk_write(RegC20, 24'h5A8000),
      mk_write(RegC21, 24'hC38000),
      mk_write(RegC30, 24'h018000),
      mk_sample(RawMax, RawMax),
      mk_sample(RawMin, RawMin),
      mk_sample(RawMax, RawMin),
      mk_sample(RawMin, RawMax),
      mk_sample(-24'sd253952, -24'sd524288),
      mk_sample(24'sd1, -24'sd1)
    };

    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_n = 1'b1;
    @(negedge clk_i);

    foreach (script[i]) begin
      if (script[i].kind == StepWrite) begin
        wait_idle();
        write_reg(script[i].sel, script[i].wdata);
      end else begin
        send_item(script[i].rp, script[i].rt, script[i].known, script[i].typed);
      end
    end

    for (int phase = 0; phase < RandPhases; phase++) begin
      wait_idle();
      for (int k = 0; k < 8; k++) write_reg(cfg_reg_e'(k), pick_coef(cfg_reg_e'(k)));
      burst_left = 0;
      for (int n = 0; n < ItemsPerPhase; n++) begin
        // hold off until the pipe has drained once
        if (phase == 3 && n == ItemsPerPhase / 2) begin
          wait_idle();
          burst_left = 0;
        end
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 48);
          gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          if (gap != 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk_i);
          end
        end
        burst_left--;
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            rp = 24'($urandom);
            rt = 24'($urandom);
          end
          4, 5: begin
            // sensor-like magnitudes, psc within a few units
            rp = 24'($urandom_range(0, 3 * 253952));
            rt = 24'($urandom_range(0, 1 << 21)) - 24'sd1048576;
            if ($urandom_range(0, 1) == 1) rp = -rp;
          end
          6: begin
            // around the normalisation clamp
            rp = PscEdge + 24'($urandom_range(0, 32)) - 24'sd16;
            rt = 24'($urandom);
            if ($urandom_range(0, 1) == 1) rp = -rp;
          end
          7: begin
            rp = extreme_value();
            rt = extreme_value();
          end
          default: begin
            rp = 24'($urandom_range(0, 8191)) - 24'sd4096;
            rt = 24'($urandom_range(0, 8191)) - 24'sd4096;
          end
        endcase
        send_item(rp, rt, 1'b0, '0);
      end
    end

    in_valid = 1'b0;
    while (pending_readings.size() != 0) @(negedge clk_i);
    repeat (2 * NumStages) @(negedge clk_i);

    $display("%0d requests under %0d register writes, %0d results compared",
             n_requests, n_writes, n_results);
    $display("clamped results: %0d temperature, %0d pressure", n_sat_temp, n_sat_pres);
    if (fail_count == 0) begin
      $display("tb_baro_pressure_temp_compensation_unit: clean");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("tb_baro_pressure_temp_compensation_unit: errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/bptc_pkg.sv
design/bptc_mulq.sv
design/baro_pressure_temp_compensation_unit.sv
tb/tb_baro_pressure_temp_compensation_unit.sv
